### sv/hdep_pkg.sv
// ----------------------------------------------------------------------------
// HTTP date parser package
// Shared types and constants for the date parser front end and converter.
// ----------------------------------------------------------------------------
package hdep_pkg;

    localparam int EPOCH_W = 39;

    // parsed fields handed from the scanner to the converter
    typedef struct packed {
        logic       bad;
        logic [6:0] day;
        logic [3:0] month;
        logic [13:0] year;
        logic [6:0] hour;
        logic [6:0] minute;
        logic [6:0] second;
    } t_fields;

    typedef logic signed [EPOCH_W-1:0] t_epoch;

    localparam logic [5:0] PH_WDAY = 6'd0;
    localparam logic [5:0] PH_SKIP = 6'd1;
    localparam logic [5:0] PH_D1   = 6'd2;
    localparam logic [5:0] PH_D2   = 6'd3;
    localparam logic [5:0] PH_DSEP = 6'd4;
    localparam logic [5:0] PH_M0   = 6'd5;
    localparam logic [5:0] PH_M1   = 6'd6;
    localparam logic [5:0] PH_M2   = 6'd7;
    localparam logic [5:0] PH_MSEP = 6'd8;
    localparam logic [5:0] PH_Y4A  = 6'd9;
    localparam logic [5:0] PH_Y4B  = 6'd10;
    localparam logic [5:0] PH_Y4C  = 6'd11;
    localparam logic [5:0] PH_Y4D  = 6'd12;
    localparam logic [5:0] PH_Y2A  = 6'd13;
    localparam logic [5:0] PH_Y2B  = 6'd14;
    localparam logic [5:0] PH_ISP  = 6'd15;
    localparam logic [5:0] PH_ID1  = 6'd16;
    localparam logic [5:0] PH_ID2  = 6'd17;
    localparam logic [5:0] PH_TSEP = 6'd18;
    localparam logic [5:0] PH_H1   = 6'd19;
    localparam logic [5:0] PH_H2   = 6'd20;
    localparam logic [5:0] PH_C1   = 6'd21;
    localparam logic [5:0] PH_MI1  = 6'd22;
    localparam logic [5:0] PH_MI2  = 6'd23;
    localparam logic [5:0] PH_C2   = 6'd24;
    localparam logic [5:0] PH_S1   = 6'd25;
    localparam logic [5:0] PH_S2   = 6'd26;
    localparam logic [5:0] PH_YSEP = 6'd27;
    localparam logic [5:0] PH_IYA  = 6'd28;
    localparam logic [5:0] PH_IYB  = 6'd29;
    localparam logic [5:0] PH_IYC  = 6'd30;
    localparam logic [5:0] PH_IYD  = 6'd31;
    localparam logic [5:0] PH_DONE = 6'd32;

    localparam logic [1:0] FMT_NONE    = 2'd0;
    localparam logic [1:0] FMT_RFC1123 = 2'd1;
    localparam logic [1:0] FMT_RFC850  = 2'd2;
    localparam logic [1:0] FMT_ISOC    = 2'd3;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        case (m)
            4'd1:                      month_len = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   month_len = 5'd30;
            default:                   month_len = 5'd31;
        endcase
    endfunction

endpackage

### sv/hdep_if.sv
// ----------------------------------------------------------------------------
// HTTP date parser channels
// Valid/ready channels for bytes, results and the configuration register.
// ----------------------------------------------------------------------------
interface hdep_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       is_last;
    modport source (output valid, output char_in, output is_last, input ready);
    modport sink   (input valid, input char_in, input is_last, output ready);
endinterface

interface hdep_out_if;
    logic              valid;
    logic              ready;
    logic signed [38:0] epoch_seconds;
    logic              failed;
    modport source (output valid, output epoch_seconds, output failed, input ready);
    modport sink   (input valid, input epoch_seconds, input failed, output ready);
endinterface

interface hdep_cfg_if;
    logic valid;
    logic ready;
    logic limit_year_2038;
    modport source (output valid, output limit_year_2038, input ready);
    modport sink   (input valid, input limit_year_2038, output ready);
endinterface

### sv/http_date_to_epoch_parser.sv
// ----------------------------------------------------------------------------
// HTTP date to epoch parser
// Parses an HTTP date byte stream into Unix seconds or a failure flag.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one string byte per word, is_last on the final byte.
//   out_ch : one word per string: epoch_seconds (signed 39 bit) and failed.
//   cfg_ch : limit_year_2038; write only while the block is idle.
// Throughput: one byte per cycle. The scanner takes a byte every cycle
//   while the field queue has room; the converter pipeline takes one
//   string per cycle while the receiver does not stall it.
// Path: the last byte's fields are written to the queue, then pass
//   through four converter stages to out_ch.
// Reset clears the scanner, queue and pipeline and sets the limit to 0.
// When the receiver stalls, the converter holds its stages; the queue
//   fills and in_ch.ready drops whenever the queue is full.
// ----------------------------------------------------------------------------
module http_date_to_epoch_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    hdep_in_if.sink    in_ch,
    hdep_out_if.source out_ch,
    hdep_cfg_if.sink   cfg_ch
);
    import hdep_pkg::*;

    logic    r_limit;
    logic    push, full, q_valid, q_pop, conv_ready, scan_valid;
    t_fields scan_fields, q_fields;

    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_limit <= 1'b0;
        else if (cfg_ch.valid) r_limit <= cfg_ch.limit_year_2038;
    end

    assign in_ch.ready = !full;
    assign scan_valid  = in_ch.valid && !full;

    hdep_scan u_scan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(scan_valid),
        .i_char(in_ch.char_in), .i_last(in_ch.is_last),
        .o_push(push), .o_fields(scan_fields)
    );

    hdep_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_data(scan_fields),
        .o_full(full), .o_valid(q_valid), .i_pop(q_pop), .o_data(q_fields)
    );

    assign q_pop = q_valid && conv_ready;

    hdep_conv u_conv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_limit(r_limit),
        .i_valid(q_valid), .o_ready(conv_ready), .i_fields(q_fields),
        .o_valid(out_ch.valid), .i_ready(out_ch.ready),
        .o_epoch(out_ch.epoch_seconds), .o_failed(out_ch.failed)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && full)) else $error("push into full queue");
    a_cfg_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !cfg_ch.valid |=> $stable(r_limit)) else $error("limit changed");
endmodule

### sv/hdep_scan.sv
// ----------------------------------------------------------------------------
// HTTP date scanner
// Walks the date grammar one byte per cycle while i_valid is high, and
// emits the parsed fields on the last byte.
// ----------------------------------------------------------------------------
module hdep_scan (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_char,
    input  logic             i_last,
    output logic             o_push,
    output hdep_pkg::t_fields o_fields
);
    import hdep_pkg::*;

    logic [5:0]  r_phase, n_phase;
    logic [1:0]  r_fmt, n_fmt;
    logic [6:0]  r_day, n_day, r_hour, n_hour, r_min, n_min, r_sec, n_sec;
    logic [3:0]  r_mon, n_mon;
    logic [13:0] r_year, n_year;
    logic [7:0]  r_l0, n_l0, r_l1, n_l1;
    logic        r_err, n_err;
    logic        is_dig;
    logic [3:0]  dig;
    logic [5:0]  ph;

    assign is_dig = (i_char >= 8'h30) && (i_char <= 8'h39);
    assign dig    = i_char[3:0];

    function automatic logic [6:0] acc7(input logic [6:0] v, input logic [3:0] d);
        acc7 = 7'((v * 7'd10) + 7'(d));
    endfunction

    function automatic logic [13:0] acc14(input logic [13:0] v, input logic [3:0] d);
        acc14 = 14'((v * 14'd10) + 14'(d));
    endfunction

    always_comb begin
        n_phase = r_phase; n_fmt = r_fmt; n_day = r_day; n_mon = r_mon;
        n_year = r_year; n_hour = r_hour; n_min = r_min; n_sec = r_sec;
        n_l0 = r_l0; n_l1 = r_l1; n_err = r_err;
        // skip states that re-dispatch the same byte are folded in here
        ph = r_phase;
        if (r_phase == PH_SKIP && i_char != 8'h20)
            ph = (r_fmt == FMT_ISOC) ? PH_M0 : PH_D1;
        else if (r_phase == PH_ISP && i_char != 8'h20)
            ph = PH_ID1;
        if (!r_err) begin
            case (ph)
                PH_WDAY: begin
                    if (i_char == 8'h2c) begin
                        n_fmt = FMT_NONE; n_phase = PH_SKIP;
                    end else if (i_char == 8'h20) begin
                        n_fmt = FMT_ISOC; n_phase = PH_SKIP;
                    end
                end
                PH_SKIP: n_phase = PH_SKIP;
                PH_D1, PH_ID1: begin
                    if (!is_dig) n_err = 1'b1;
                    else begin
                        n_day = 7'(dig);
                        n_phase = (ph == PH_D1) ? PH_D2 : PH_ID2;
                    end
                end
                PH_D2: begin
                    if (!is_dig) n_err = 1'b1;
                    else begin n_day = acc7(r_day, dig); n_phase = PH_DSEP; end
                end
                PH_DSEP: begin
                    if (i_char == 8'h20) begin
                        n_fmt = FMT_RFC1123; n_phase = PH_M0;
                    end else if (i_char == 8'h2d) begin
                        n_fmt = FMT_RFC850; n_phase = PH_M0;
                    end else n_err = 1'b1;
                end
                PH_M0: begin n_l0 = i_char; n_l1 = 8'h00; n_phase = PH_M1; end
                PH_M1: begin n_l1 = i_char; n_phase = PH_M2; end
                PH_M2: begin
                    n_phase = PH_MSEP;
                    case (r_l0)
                        8'h4a: n_mon = (r_l1 == 8'h61) ? 4'd0 :
                                       (i_char == 8'h6e) ? 4'd5 : 4'd6;
                        8'h46: n_mon = 4'd1;
                        8'h4d: n_mon = (i_char == 8'h72) ? 4'd2 : 4'd4;
                        8'h41: n_mon = (r_l1 == 8'h70) ? 4'd3 : 4'd7;
                        8'h53: n_mon = 4'd8;
                        8'h4f: n_mon = 4'd9;
                        8'h4e: n_mon = 4'd10;
                        8'h44: n_mon = 4'd11;
                        default: begin n_err = 1'b1; n_phase = PH_M2; end
                    endcase
                end
                PH_MSEP: begin
                    if (r_fmt == FMT_RFC1123) begin
                        if (i_char != 8'h20) n_err = 1'b1; else n_phase = PH_Y4A;
                    end else if (r_fmt == FMT_RFC850) begin
                        if (i_char != 8'h2d) n_err = 1'b1; else n_phase = PH_Y2A;
                    end else n_phase = PH_ISP;
                end
                PH_Y4A, PH_Y4B, PH_Y4C, PH_Y4D, PH_Y2A, PH_IYA, PH_IYB, PH_IYC,
                PH_IYD: begin
                    if (!is_dig) n_err = 1'b1;
                    else begin
                        n_year = acc14(r_year, dig);
                        case (ph)
                            PH_Y4D:  n_phase = PH_TSEP;
                            PH_Y2A:  n_phase = PH_Y2B;
                            PH_IYD:  n_phase = PH_DONE;
                            default: n_phase = ph + 6'd1;
                        endcase
                    end
                end
                PH_Y2B: begin
                    if (!is_dig) n_err = 1'b1;
                    else begin
                        n_year = acc14(r_year, dig);
                        n_year = n_year + ((n_year < 14'd70) ? 14'd2000 : 14'd1900);
                        n_phase = PH_TSEP;
                    end
                end
                PH_ISP: n_phase = PH_ID1;
                PH_ID2: begin
                    if (i_char == 8'h20) n_phase = PH_H1;
                    else if (!is_dig) n_err = 1'b1;
                    else begin n_day = acc7(r_day, dig); n_phase = PH_TSEP; end
                end
                PH_TSEP: if (i_char != 8'h20) n_err = 1'b1; else n_phase = PH_H1;
                PH_C1:   if (i_char != 8'h3a) n_err = 1'b1; else n_phase = PH_MI1;
                PH_C2:   if (i_char != 8'h3a) n_err = 1'b1; else n_phase = PH_S1;
                PH_H1, PH_H2: begin
                    if (!is_dig) n_err = 1'b1;
                    else begin
                        n_hour = acc7(r_hour, dig);
                        n_phase = (ph == PH_H1) ? PH_H2 : PH_C1;
                    end
                end
                PH_MI1, PH_MI2: begin
                    if (!is_dig) n_err = 1'b1;
                    else begin
                        n_min = acc7(r_min, dig);
                        n_phase = (ph == PH_MI1) ? PH_MI2 : PH_C2;
                    end
                end
                PH_S1: begin
                    if (!is_dig) n_err = 1'b1;
                    else begin n_sec = acc7(r_sec, dig); n_phase = PH_S2; end
                end
                PH_S2: begin
                    if (!is_dig) n_err = 1'b1;
                    else begin
                        n_sec = acc7(r_sec, dig);
                        n_phase = (r_fmt == FMT_ISOC) ? PH_YSEP : PH_DONE;
                    end
                end
                PH_YSEP: begin
                    if (i_char != 8'h20) n_err = 1'b1;
                    else begin n_year = '0; n_phase = PH_IYA; end
                end
                default: ;
            endcase
        end
    end

    assign o_push = i_valid && i_last;
    always_comb begin
        o_fields.bad    = n_err || (n_phase != PH_DONE);
        o_fields.day    = n_day;
        o_fields.month  = n_mon;
        o_fields.year   = n_year;
        o_fields.hour   = n_hour;
        o_fields.minute = n_min;
        o_fields.second = n_sec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && i_last)) begin
            r_phase <= PH_WDAY; r_fmt <= FMT_NONE; r_day <= '0; r_mon <= '0;
            r_year <= '0; r_hour <= '0; r_min <= '0; r_sec <= '0;
            r_l0 <= '0; r_l1 <= '0; r_err <= 1'b0;
        end else if (i_valid) begin
            r_phase <= n_phase; r_fmt <= n_fmt; r_day <= n_day; r_mon <= n_mon;
            r_year <= n_year; r_hour <= n_hour; r_min <= n_min; r_sec <= n_sec;
            r_l0 <= n_l0; r_l1 <= n_l1; r_err <= n_err;
        end
    end

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_DONE) else $error("phase out of range");
    a_reset_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_last) |=> (r_phase == PH_WDAY && !r_err)) else $error("no clear");
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err && !(i_valid && i_last)) |=> r_err) else $error("error dropped");
endmodule

### sv/hdep_fifo.sv
// ----------------------------------------------------------------------------
// HTTP date field queue
// Small register queue between the scanner and the converter.
// ----------------------------------------------------------------------------
module hdep_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hdep_pkg::t_fields i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_pop,
    output hdep_pkg::t_fields o_data
);
    import hdep_pkg::*;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_fields        r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid)) else $error("queue underflow");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("count range");
endmodule

### sv/hdep_conv.sv
// ----------------------------------------------------------------------------
// HTTP date converter
// Range checks the fields and turns them into epoch seconds in a pipeline.
// ----------------------------------------------------------------------------
module hdep_conv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_limit,
    input  logic              i_valid,
    output logic              o_ready,
    input  hdep_pkg::t_fields i_fields,
    output logic              o_valid,
    input  logic              i_ready,
    output hdep_pkg::t_epoch  o_epoch,
    output logic              o_failed
);
    import hdep_pkg::*;

    // stage 1: checks, shifted year/month, quotient terms
    logic        s1_bad;
    logic signed [15:0] y1;
    logic [3:0]  m1;
    logic        leap;
    logic [13:0] yr;

    // stage registers
    logic        r1_v, r2_v, r3_v, r_ov;
    logic        r1_bad, r2_bad, r3_bad;
    logic signed [22:0] r1_yd;      // 365*y + leap terms
    logic [8:0]  r1_md;             // (367*m)/12
    logic [6:0]  r1_day, r2_hh, r1_hh, r1_mi, r1_ss, r2_mi, r2_ss;
    logic signed [22:0] r2_days;
    logic signed [38:0] r3_dsec;
    logic [16:0] r3_tsec;
    logic        adv;

    logic signed [15:0] yp;
    logic [15:0] q4, q100, q400;
    // divide by 100 as multiply by ceil(2^20/100), exact below 2^14
    logic [27:0] yr_prod, yp_prod;
    logic [7:0]  yr_q100;

    // (367*m)/12 for the March-based month
    function automatic logic [8:0] cum_days(input logic [3:0] m);
        case (m)
            4'd1:    cum_days = 9'd30;
            4'd2:    cum_days = 9'd61;
            4'd3:    cum_days = 9'd91;
            4'd4:    cum_days = 9'd122;
            4'd5:    cum_days = 9'd152;
            4'd6:    cum_days = 9'd183;
            4'd7:    cum_days = 9'd214;
            4'd8:    cum_days = 9'd244;
            4'd9:    cum_days = 9'd275;
            4'd10:   cum_days = 9'd305;
            4'd11:   cum_days = 9'd336;
            4'd12:   cum_days = 9'd367;
            default: cum_days = 9'd0;
        endcase
    endfunction

    assign yr = i_fields.year;
    always_comb begin
        yr_prod = 28'(yr) * 28'd10486;
        yr_q100 = yr_prod[27:20];
        leap = (yr[1:0] == 2'b00)
            && !((yr == 14'(yr_q100 * 14'd100)) && (yr_q100[1:0] != 2'b00));
        s1_bad = i_fields.bad || i_fields.hour > 7'd23 || i_fields.minute > 7'd59
              || i_fields.second > 7'd59 || i_fields.month > 4'd11;
        if (i_fields.day == 7'd29 && i_fields.month == 4'd1) begin
            if (!leap) s1_bad = 1'b1;
        end else if (i_fields.day > 7'(month_len(i_fields.month))) begin
            s1_bad = 1'b1;
        end
        if (i_limit && yr >= 14'd2038) s1_bad = 1'b1;
        if (i_fields.month <= 4'd1) begin
            m1 = i_fields.month + 4'd11; y1 = $signed(16'(yr)) - 16'sd1;
        end else begin
            m1 = i_fields.month - 4'd1; y1 = $signed(16'(yr));
        end
        yp      = y1 + 16'sd400;        // always positive
        q4      = 16'($unsigned(yp)) >> 2;
        yp_prod = 28'($unsigned(yp)) * 28'd10486;
        q100    = 16'(yp_prod[27:20]);
        q400    = q100 >> 2;
    end

    assign adv     = !r_ov || i_ready;
    assign o_ready = adv;
    assign o_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_bad <= s1_bad;
            r1_yd  <= 23'(y1 * 23'sd365) + 23'($signed({1'b0, q4}))
                    - 23'($signed({1'b0, q100})) + 23'($signed({1'b0, q400})) - 23'sd97;
            r1_md  <= cum_days(m1);
            r1_day <= i_fields.day; r1_hh <= i_fields.hour;
            r1_mi  <= i_fields.minute; r1_ss <= i_fields.second;
            r2_bad <= r1_bad;
            r2_days <= r1_yd + 23'($signed({1'b0, r1_md})) + 23'($signed({1'b0, r1_day}))
                     - 23'sd719527 - 23'sd31 + 23'sd59;
            r2_hh <= r1_hh; r2_mi <= r1_mi; r2_ss <= r1_ss;
            r3_bad  <= r2_bad;
            r3_dsec <= 39'(r2_days) * 39'sd86400;
            r3_tsec <= 17'(r2_hh * 17'd3600) + 17'(r2_mi * 17'd60) + 17'(r2_ss);
            o_failed <= r3_bad;
            o_epoch  <= r3_bad ? '0 : r3_dsec + 39'($signed({1'b0, r3_tsec}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0; r_ov <= 1'b0;
        end else if (adv) begin
            r1_v <= i_valid; r2_v <= r1_v; r3_v <= r2_v; r_ov <= r3_v;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |=> (r_ov && $stable(o_epoch))) else $error("result lost");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && o_failed) |-> (o_epoch == '0)) else $error("failed not zero");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r3_v) |=> r_ov) else $error("result dropped");
endmodule

### dv/hdep_date_checker.sv
// ----------------------------------------------------------------------------
// HTTP date parser checker
// Watches the byte, result and config channels, predicts each conversion
// and compares every result word field by field against the oldest
// pending expectation.
// ----------------------------------------------------------------------------
module hdep_date_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    hdep_in_if   in_ch,
    hdep_out_if  out_ch,
    hdep_cfg_if  cfg_ch,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);
    import hdep_pkg::*;

    typedef struct {
        t_epoch secs;
        logic   failed;
    } t_date_result;

    t_date_result dates_due[$];

    logic        limit_2038;
    logic [5:0]  phase;
    logic [1:0]  fmt;
    logic [6:0]  day_v;
    logic [3:0]  mon_v;
    logic [13:0] year_v;
    logic [6:0]  hour_v;
    logic [6:0]  min_v;
    logic [6:0]  sec_v;
    logic [15:0] mon_letters;
    logic        err;

    int fails;
    int checked;

    assign o_fail_count = fails;
    assign o_pending    = dates_due.size();
    assign o_checked    = checked;

    function automatic void clear_scan();
        phase = PH_WDAY;
        fmt = FMT_NONE;
        day_v = 0;
        mon_v = 0;
        year_v = 0;
        hour_v = 0;
        min_v = 0;
        sec_v = 0;
        mon_letters = 0;
        err = 0;
    endfunction

    // two-digit field accumulate; a non-digit poisons the string
    function automatic void add_digit(ref logic [6:0] fld, input int d, input logic [5:0] nxt);
        if (d < 0) begin
            err = 1;
        end else begin
            fld = 7'(fld * 10 + d);
            phase = nxt;
        end
    endfunction

    function automatic void add_year_digit(input int d, input logic [5:0] nxt);
        if (d < 0) begin
            err = 1;
        end else begin
            year_v = 14'(year_v * 10 + d);
            phase = nxt;
        end
    endfunction

    function automatic void pick_month(input logic [7:0] l2);
        logic [7:0] l0;
        logic [7:0] l1;
        l0 = mon_letters[7:0];
        l1 = mon_letters[15:8];
        case (l0)
            "J": mon_v = (l1 == "a") ? 4'd0 : (l2 == "n") ? 4'd5 : 4'd6;
            "F": mon_v = 4'd1;
            "M": mon_v = (l2 == "r") ? 4'd2 : 4'd4;
            "A": mon_v = (l1 == "p") ? 4'd3 : 4'd7;
            "S": mon_v = 4'd8;
            "O": mon_v = 4'd9;
            "N": mon_v = 4'd10;
            "D": mon_v = 4'd11;
            default: begin
                err = 1;
                return;
            end
        endcase
        phase = PH_MSEP;
    endfunction

    function automatic void scan_byte(input logic [7:0] c);
        int d;
        bit again;
        d = (c >= "0" && c <= "9") ? int'(c) - int'("0") : -1;
        again = 1;
        while (again && !err) begin
            again = 0;
            case (phase)
                PH_WDAY: begin
                    if (c == ",") begin
                        fmt = FMT_NONE;
                        phase = PH_SKIP;
                    end else if (c == " ") begin
                        fmt = FMT_ISOC;
                        phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    if (c != " ") begin
                        phase = (fmt == FMT_ISOC) ? PH_M0 : PH_D1;
                        again = 1;
                    end
                end
                PH_D1: begin
                    day_v = 0;
                    add_digit(day_v, d, PH_D2);
                end
                PH_D2: add_digit(day_v, d, PH_DSEP);
                PH_DSEP: begin
                    if (c == " ") begin
                        fmt = FMT_RFC1123;
                        phase = PH_M0;
                    end else if (c == "-") begin
                        fmt = FMT_RFC850;
                        phase = PH_M0;
                    end else begin
                        err = 1;
                    end
                end
                PH_M0: begin
                    mon_letters = {8'h00, c};
                    phase = PH_M1;
                end
                PH_M1: begin
                    mon_letters[15:8] = c;
                    phase = PH_M2;
                end
                PH_M2: pick_month(c);
                PH_MSEP: begin
                    if (fmt == FMT_RFC1123) begin
                        if (c != " ") err = 1;
                        else phase = PH_Y4A;
                    end else if (fmt == FMT_RFC850) begin
                        if (c != "-") err = 1;
                        else phase = PH_Y2A;
                    end else begin
                        phase = PH_ISP;
                    end
                end
                PH_Y4A: add_year_digit(d, PH_Y4B);
                PH_Y4B: add_year_digit(d, PH_Y4C);
                PH_Y4C: add_year_digit(d, PH_Y4D);
                PH_Y4D: add_year_digit(d, PH_TSEP);
                PH_Y2A: add_year_digit(d, PH_Y2B);
                PH_Y2B: begin
                    add_year_digit(d, PH_TSEP);
                    if (!err) year_v = year_v + ((year_v < 70) ? 14'd2000 : 14'd1900);
                end
                PH_ISP: begin
                    phase = PH_ID1;
                    if (c != " ") again = 1;
                end
                PH_ID1: begin
                    day_v = 0;
                    add_digit(day_v, d, PH_ID2);
                end
                PH_ID2: begin
                    if (c == " ") phase = PH_H1;
                    else add_digit(day_v, d, PH_TSEP);
                end
                PH_TSEP: begin
                    if (c != " ") err = 1;
                    else phase = PH_H1;
                end
                PH_H1: add_digit(hour_v, d, PH_H2);
                PH_H2: add_digit(hour_v, d, PH_C1);
                PH_C1: begin
                    if (c != ":") err = 1;
                    else phase = PH_MI1;
                end
                PH_MI1: add_digit(min_v, d, PH_MI2);
                PH_MI2: add_digit(min_v, d, PH_C2);
                PH_C2: begin
                    if (c != ":") err = 1;
                    else phase = PH_S1;
                end
                PH_S1: add_digit(sec_v, d, PH_S2);
                PH_S2: add_digit(sec_v, d, (fmt == FMT_ISOC) ? PH_YSEP : PH_DONE);
                PH_YSEP: begin
                    if (c != " ") begin
                        err = 1;
                    end else begin
                        year_v = 0;
                        phase = PH_IYA;
                    end
                end
                PH_IYA: add_year_digit(d, PH_IYB);
                PH_IYB: add_year_digit(d, PH_IYC);
                PH_IYC: add_year_digit(d, PH_IYD);
                PH_IYD: add_year_digit(d, PH_DONE);
                default: ;
            endcase
        end
    endfunction

    // range checks, then days from civil date with a March-based year
    function automatic bit to_seconds(output longint secs);
        longint y;
        longint m;
        longint days;
        int mlen[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        secs = 0;
        if (hour_v > 23 || min_v > 59 || sec_v > 59) return 0;
        if (mon_v > 11) return 0;
        if (day_v == 29 && mon_v == 1) begin
            if (year_v[1:0] != 0 || (year_v % 100 == 0 && year_v % 400 != 0)) return 0;
        end else if (day_v > mlen[mon_v]) begin
            return 0;
        end
        if (limit_2038 && year_v >= 2038) return 0;
        y = longint'(year_v);
        m = longint'(mon_v);
        if (m <= 1) begin
            m += 11;
            y -= 1;
        end else begin
            m -= 1;
        end
        days = 365 * y + (y + 400) / 4 - (y + 400) / 100 + (y + 400) / 400 - 97
             + (367 * m) / 12 - 31 + longint'(day_v) - 719527 + 31 + 28;
        secs = days * 86400 + longint'(hour_v) * 3600 + longint'(min_v) * 60
             + longint'(sec_v);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_date_result exp_r;
        t_date_result got;
        longint secs;
        bit ok;
        if (!i_rst_n) begin
            limit_2038 <= 0;
            clear_scan();
            dates_due.delete();
            fails <= 0;
            checked <= 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) limit_2038 <= cfg_ch.limit_year_2038;
            if (in_ch.valid && in_ch.ready) begin
                scan_byte(in_ch.char_in);
                if (in_ch.is_last) begin
                    ok = !err && phase == PH_DONE && to_seconds(secs);
                    exp_r.secs = ok ? t_epoch'(secs) : '0;
                    exp_r.failed = !ok;
                    dates_due.push_back(exp_r);
                    clear_scan();
                end
            end
            if (out_ch.valid && out_ch.ready) begin
                got.secs = out_ch.epoch_seconds;
                got.failed = out_ch.failed;
                checked <= checked + 1;
                if (dates_due.size() == 0) begin
                    $error("unexpected result word: epoch_seconds %0d failed %0b",
                           got.secs, got.failed);
                    fails <= fails + 1;
                end else begin
                    exp_r = dates_due.pop_front();
                    if (got.secs !== exp_r.secs) begin
                        $error("epoch_seconds: expected %0d, got %0d", exp_r.secs, got.secs);
                        fails <= fails + 1;
                    end else if (got.failed !== exp_r.failed) begin
                        $error("failed: expected %0b, got %0b", exp_r.failed, got.failed);
                        fails <= fails + 1;
                    end
                end
            end
        end
    end

endmodule

### dv/tb_http_date_to_epoch_parser.sv
// ----------------------------------------------------------------------------
// HTTP date parser testbench
// Feeds directed and random date strings in all three layouts, with
// malformed, truncated and padded variants, under changing stall patterns
// and year limit settings; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_http_date_to_epoch_parser;
    import hdep_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 12;

    logic i_clk;
    logic i_rst_n;

    hdep_in_if  in_ch ();
    hdep_out_if out_ch ();
    hdep_cfg_if cfg_ch ();

    int fail_count;
    int pending;
    int checked;
    int send_idle;
    int recv_idle;
    int strings_sent;
    int stall_cycles;
    byte unsigned date_bytes[$];

    string month_names[12] = '{"Jan", "Feb", "Mar", "Apr", "May", "Jun",
                               "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"};
    string wday_names[7] = '{"Mon", "Tue", "Wed", "Thu", "Fri", "Sat", "Sunday"};
    string month_firsts = "JMADFSON";

    http_date_to_epoch_parser u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    hdep_date_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_ch      (cfg_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    // watchdog: cycles without any accepted word
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready) || !i_rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) date_bytes.push_back(s[i]);
    endtask

    // sends the queued string, is_last on its final byte
    task automatic send_date();
        for (int i = 0; i < date_bytes.size(); i++) begin
            while ($urandom_range(99) < send_idle) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
            in_ch.valid   <= 1'b1;
            in_ch.char_in <= date_bytes[i];
            in_ch.is_last <= (i == date_bytes.size() - 1);
            do @(posedge i_clk); while (!in_ch.ready);
        end
        in_ch.valid <= 1'b0;
        if (date_bytes.size() > 0) strings_sent++;
        date_bytes.delete();
    endtask

    task automatic send_text(input string s);
        push_text(s);
        send_date();
    endtask

    // waits for the checker to log the last string and for no result to be pending, then drains
    task automatic wait_idle();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic val);
        wait_idle();
        cfg_ch.valid           <= 1'b1;
        cfg_ch.limit_year_2038 <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic string rand_month();
        byte unsigned a;
        byte unsigned b;
        byte unsigned c;
        if ($urandom_range(9) != 0) return month_names[$urandom_range(11)];
        a = month_firsts[$urandom_range(7)];
        b = 8'($urandom_range(8'h41, 8'h7a));
        c = 8'($urandom_range(8'h41, 8'h7a));
        return $sformatf("%c%c%c", a, b, c);
    endfunction

    function automatic int rand_year();
        case ($urandom_range(5))
            0: return $urandom_range(9999);
            1: return $urandom_range(2030, 2045);
            2: return 100 * $urandom_range(0, 99);
            default: return $urandom_range(1950, 2100);
        endcase
    endfunction

    // one random date, mostly well formed, sometimes damaged
    task automatic random_date();
        string wd;
        string mo;
        int day;
        int hr;
        int mi;
        int se;
        int yr;
        int pos;
        wd  = wday_names[$urandom_range(6)];
        mo  = rand_month();
        day = ($urandom_range(3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 29);
        hr  = ($urandom_range(19) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
        mi  = ($urandom_range(19) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
        se  = ($urandom_range(19) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
        yr  = rand_year();
        case ($urandom_range(2))
            0: push_text($sformatf("%s, %02d %s %04d %02d:%02d:%02d",
                                   wd, day, mo, yr, hr, mi, se));
            1: push_text($sformatf("%s, %02d-%s-%02d %02d:%02d:%02d",
                                   wd, day, mo, yr % 100, hr, mi, se));
            default: begin
                if (day < 10 && $urandom_range(1))
                    push_text($sformatf("%s %s  %0d %02d:%02d:%02d %04d",
                                        wd, mo, day, hr, mi, se, yr));
                else
                    push_text($sformatf("%s %s %02d %02d:%02d:%02d %04d",
                                        wd, mo, day, hr, mi, se, yr));
            end
        endcase
        case ($urandom_range(19))
            0, 1: date_bytes[$urandom_range(date_bytes.size() - 1)] = 8'($urandom_range(255));
            2: begin
                pos = $urandom_range(1, date_bytes.size() - 1);
                while (date_bytes.size() > pos) void'(date_bytes.pop_back());
            end
            3, 4: repeat ($urandom_range(1, 4)) date_bytes.push_back(8'($urandom_range(255)));
            5: begin
                date_bytes.delete();
                repeat ($urandom_range(1, 12)) date_bytes.push_back(8'($urandom_range(255)));
            end
            default: ;
        endcase
        send_date();
    endtask

    task automatic random_phase(input int s_idle, input int r_idle, input int n);
        send_idle = s_idle;
        recv_idle = r_idle;
        repeat (n) random_date();
    endtask

    initial begin
        i_rst_n                <= 1'b0;
        in_ch.valid            <= 1'b0;
        in_ch.char_in          <= 8'h00;
        in_ch.is_last          <= 1'b0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.limit_year_2038 <= 1'b0;
        send_idle    = 0;
        recv_idle    = 0;
        strings_sent = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_limit(1'b0);
        send_text("Tue, 10 Nov 2002 23:50:13");
        send_text("Tuesday, 10-Dec-02 23:50:13");
        send_text("Tue Dec 10 23:50:13 2002");
        send_text("Thu Jan  1 00:00:00 1970");
        send_text("Sat, 01 Jan 0000 00:00:00");
        send_text("Fri, 31 Dec 9999 23:59:59");
        send_text("Tue, 29 Feb 2000 12:00:00");
        send_text("Thu, 29 Feb 1900 12:00:00");
        send_text("Tue, 29 Feb 0000 12:00:00");
        send_text("Sun, 00 Mar 2020 00:00:00");
        send_text("Sun, 31 Apr 2020 00:00:00");
        send_text("Sun, 10 Jun 2020 24:00:00");
        send_text("Sun, 10 Jul 2020 10:60:59");
        send_text("Sun, 10 Aug 2020 10:59:60");
        send_text("Sun, 10-May-69 01:02:03");
        send_text("Sun, 10-Sep-70 01:02:03 trailing junk");
        send_text("Mon, 18 Jan 2038 03:14:07");
        send_text("Mon, 10 Xyz 2020 00:00:00");
        send_text("Mon, 10 Oct 2020 00:00");
        send_text("Weekday");
        date_bytes = '{8'h00, 8'hff, 8'h2c, 8'h20, 8'h20};
        push_text("5 Mar 2001 11:22:33");
        date_bytes.push_back(8'hff);
        send_date();
        write_limit(1'b1);
        send_text("Mon, 18 Jan 2038 03:14:07");
        send_text("Fri, 31 Dec 2037 23:59:59");

        random_phase(22, 85, 4);
        write_limit(1'b0);
        random_phase(85, 22, 4);
        write_limit(1'b1);
        random_phase(0, 0, 4);

        wait_idle();
        $display("Sent %0d date strings in three layouts, %0d results checked,",
                 strings_sent, checked);
        $display("with both year limit settings and varied stall patterns.");
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
